// ----- hw/rtl/ahr_pkg.sv -----
// ahr_pkg: widths, fixed-point constants, register indexes and the job record
// shared by the altitude hue ramp front end, queue and back end.
// No dependencies.
`default_nettype none

package ahr_pkg;

    // field widths
    localparam int ALT_W      = 17;
    localparam int HUE_W      = 9;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // altitude differences, quotient and hue span
    localparam int DIFF_W     = ALT_W + 1;
    localparam int T_W        = 17;
    localparam int SPAN_W     = HUE_W + 1;
    localparam int PROD_W     = T_W + 1 + SPAN_W;
    localparam int HSUM_W     = HUE_W + 8 + 3;
    localparam int HUE_Q8_W   = HUE_W + 8;
    localparam int RP_W       = 14;
    localparam int PP_W       = 30;
    localparam int NUM_W      = PP_W - 10;
    localparam int RQ_W       = 41;
    localparam int CH_W       = 16;
    localparam int ACC_W      = 22;

    // pipeline depths
    localparam int DIV_STEPS   = T_W;
    localparam int BACK_STAGES = DIV_STEPS + 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // color math, q16 channels and q8 degrees
    localparam int CHROMA_Q16  = 55706;
    localparam int OFFSET_Q16  = 32768 - CHROMA_Q16 / 2;
    localparam int GRAY_Q16    = 26214;
    localparam int SECTOR_Q8   = 15360;
    localparam int TURN_Q8     = 360 * SECTOR_Q8 / 60;
    localparam int HALF_Q16    = 32768;
    // floor(n / 15) = (n * RECIP_15) >> RECIP_SHIFT for n below 2^20
    localparam int RECIP_15    = 1118482;
    localparam int RECIP_SHIFT = 24;

    localparam int GRAY_R = (GRAY_Q16 * 31 + HALF_Q16) >> 16;
    localparam int GRAY_G = (GRAY_Q16 * 63 + HALF_Q16) >> 16;
    localparam logic [PIX_W-1:0] GRAY_PIXEL =
        PIX_W'((GRAY_R << 11) | (GRAY_G << 5) | GRAY_R);

    // register reset values
    localparam logic signed [ALT_W-1:0] LOW_ALT_RST  = ALT_W'(2000);
    localparam logic signed [ALT_W-1:0] MID_ALT_RST  = ALT_W'(10000);
    localparam logic signed [ALT_W-1:0] HIGH_ALT_RST = ALT_W'(40000);
    localparam logic [HUE_W-1:0]        LOW_HUE_RST  = HUE_W'(20);
    localparam logic [HUE_W-1:0]        MID_HUE_RST  = HUE_W'(140);
    localparam logic [HUE_W-1:0]        HIGH_HUE_RST = HUE_W'(300);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_LOW_ALT  = CFG_IDX_W'(0),
        REG_STOP_MID_ALT  = CFG_IDX_W'(1),
        REG_STOP_HIGH_ALT = CFG_IDX_W'(2),
        REG_STOP_LOW_HUE  = CFG_IDX_W'(3),
        REG_STOP_MID_HUE  = CFG_IDX_W'(4),
        REG_STOP_HIGH_HUE = CFG_IDX_W'(5)
    } ahr_reg_idx_t;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic                     gray;
        logic                     interp;
        logic [HUE_W-1:0]         base_hue;
        logic signed [SPAN_W-1:0] span;
        logic [DIFF_W-1:0]        num;
        logic [DIFF_W-1:0]        den;
    } ahr_job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ahr_ifs.sv -----
// ahr_ifs: valid/ready channel interfaces for the altitude input, the pixel
// output and the configuration write port.
// Depends on ahr_pkg.
`default_nettype none

interface ahr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            alt_valid;
    logic signed [ahr_pkg::ALT_W-1:0] alt_feet;

    modport source (output valid, output alt_valid, output alt_feet, input ready);
    modport sink   (input valid, input alt_valid, input alt_feet, output ready);
endinterface

interface ahr_out_if;
    logic                      valid;
    logic                      ready;
    logic [ahr_pkg::PIX_W-1:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

interface ahr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ahr_pkg::CFG_IDX_W-1:0]  index;
    logic [ahr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ahr_front.sv -----
// ahr_front: stop registers, altitude classification against the stops and
// the one-entry job register feeding the queue.
// Depends on ahr_pkg and ahr_ifs.
`default_nettype none

module ahr_front (
    input  logic              clk,
    input  logic              rst_n,
    ahr_cfg_if.sink           cfg,
    ahr_in_if.sink            alt_in,
    output ahr_pkg::ahr_job_t job,
    output logic              job_valid,
    input  logic              job_ready
);

    logic signed [ahr_pkg::ALT_W-1:0] low_alt_reg, low_alt_next;
    logic signed [ahr_pkg::ALT_W-1:0] mid_alt_reg, mid_alt_next;
    logic signed [ahr_pkg::ALT_W-1:0] high_alt_reg, high_alt_next;
    logic [ahr_pkg::HUE_W-1:0]        low_hue_reg, low_hue_next;
    logic [ahr_pkg::HUE_W-1:0]        mid_hue_reg, mid_hue_next;
    logic [ahr_pkg::HUE_W-1:0]        high_hue_reg, high_hue_next;

    ahr_pkg::ahr_job_t job_reg, job_next;
    logic              job_vld_reg, job_vld_next;
    logic              accept;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        low_alt_next  = low_alt_reg;
        mid_alt_next  = mid_alt_reg;
        high_alt_next = high_alt_reg;
        low_hue_next  = low_hue_reg;
        mid_hue_next  = mid_hue_reg;
        high_hue_next = high_hue_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ahr_pkg::REG_STOP_LOW_ALT:  low_alt_next  = cfg.data;
                ahr_pkg::REG_STOP_MID_ALT:  mid_alt_next  = cfg.data;
                ahr_pkg::REG_STOP_HIGH_ALT: high_alt_next = cfg.data;
                ahr_pkg::REG_STOP_LOW_HUE:  low_hue_next  = cfg.data[ahr_pkg::HUE_W-1:0];
                ahr_pkg::REG_STOP_MID_HUE:  mid_hue_next  = cfg.data[ahr_pkg::HUE_W-1:0];
                ahr_pkg::REG_STOP_HIGH_HUE: high_hue_next = cfg.data[ahr_pkg::HUE_W-1:0];
                default: ;
            endcase
        end
    end

    // segment pick; an interpolated segment always has hi above lo here
    always_comb
    begin
        job_next          = '0;
        job_next.base_hue = high_hue_reg;
        if (!alt_in.alt_valid)
        begin
            job_next.gray = 1'b1;
        end
        else if (alt_in.alt_feet <= low_alt_reg)
        begin
            job_next.base_hue = low_hue_reg;
        end
        else if (alt_in.alt_feet <= mid_alt_reg)
        begin
            job_next.interp   = 1'b1;
            job_next.base_hue = low_hue_reg;
            job_next.span     = {1'b0, mid_hue_reg} - {1'b0, low_hue_reg};
            job_next.num      = ahr_pkg::DIFF_W'(alt_in.alt_feet)
                              - ahr_pkg::DIFF_W'(low_alt_reg);
            job_next.den      = ahr_pkg::DIFF_W'(mid_alt_reg)
                              - ahr_pkg::DIFF_W'(low_alt_reg);
        end
        else if (alt_in.alt_feet <= high_alt_reg)
        begin
            job_next.interp   = 1'b1;
            job_next.base_hue = mid_hue_reg;
            job_next.span     = {1'b0, high_hue_reg} - {1'b0, mid_hue_reg};
            job_next.num      = ahr_pkg::DIFF_W'(alt_in.alt_feet)
                              - ahr_pkg::DIFF_W'(mid_alt_reg);
            job_next.den      = ahr_pkg::DIFF_W'(high_alt_reg)
                              - ahr_pkg::DIFF_W'(mid_alt_reg);
        end
    end

    assign alt_in.ready = !job_vld_reg || job_ready;
    assign accept       = alt_in.valid && alt_in.ready;

    always_comb
    begin
        job_vld_next = job_vld_reg;
        if (accept)
        begin
            job_vld_next = 1'b1;
        end
        else if (job_ready)
        begin
            job_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_alt_reg  <= ahr_pkg::LOW_ALT_RST;
            mid_alt_reg  <= ahr_pkg::MID_ALT_RST;
            high_alt_reg <= ahr_pkg::HIGH_ALT_RST;
            low_hue_reg  <= ahr_pkg::LOW_HUE_RST;
            mid_hue_reg  <= ahr_pkg::MID_HUE_RST;
            high_hue_reg <= ahr_pkg::HIGH_HUE_RST;
            job_vld_reg  <= 1'b0;
        end
        else
        begin
            low_alt_reg  <= low_alt_next;
            mid_alt_reg  <= mid_alt_next;
            high_alt_reg <= high_alt_next;
            low_hue_reg  <= low_hue_next;
            mid_hue_reg  <= mid_hue_next;
            high_hue_reg <= high_hue_next;
            job_vld_reg  <= job_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job       = job_reg;
    assign job_valid = job_vld_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ahr_queue.sv -----
// ahr_queue: short first-in first-out buffer of classified jobs between the
// front end and the back end.
// Depends on ahr_pkg.
`default_nettype none

module ahr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ahr_pkg::ahr_job_t push_data,
    input  logic              push_valid,
    output logic              push_ready,
    output ahr_pkg::ahr_job_t pop_data,
    output logic              pop_valid,
    input  logic              pop_ready
);

    ahr_pkg::ahr_job_t               mem_reg [ahr_pkg::QUEUE_DEPTH];
    logic [ahr_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ahr_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ahr_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                            push;
    logic                            pop;

    assign push_ready = cnt_reg != ahr_pkg::QCNT_W'(ahr_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ahr_pkg::QPTR_W'(ahr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ahr_pkg::QPTR_W'(ahr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ahr_back.sv -----
// ahr_back: pipelined restoring divider for the ramp fraction, hue
// interpolation, hsl to rgb565 conversion and the output register.
// Depends on ahr_pkg and ahr_ifs.
`default_nettype none

module ahr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ahr_pkg::ahr_job_t job,
    input  logic              job_valid,
    output logic              job_ready,
    ahr_out_if.source         pix_out
);

    typedef struct packed {
        logic                              gray;
        logic                              interp;
        logic [ahr_pkg::HUE_W-1:0]         base_hue;
        logic signed [ahr_pkg::SPAN_W-1:0] span;
        logic [ahr_pkg::DIFF_W-1:0]        den;
        logic [ahr_pkg::DIFF_W-1:0]        rem;
        logic [ahr_pkg::T_W-1:0]           quo;
    } div_stage_t;

    localparam int LAST = ahr_pkg::BACK_STAGES - 1;

    function automatic logic [4:0] chan5(input logic [ahr_pkg::CH_W-1:0] v);
        logic [ahr_pkg::ACC_W-1:0] acc;
        acc = ahr_pkg::ACC_W'(v) * ahr_pkg::ACC_W'(31) + ahr_pkg::ACC_W'(ahr_pkg::HALF_Q16);
        return acc[20:16];
    endfunction

    function automatic logic [5:0] chan6(input logic [ahr_pkg::CH_W-1:0] v);
        logic [ahr_pkg::ACC_W-1:0] acc;
        acc = ahr_pkg::ACC_W'(v) * ahr_pkg::ACC_W'(63) + ahr_pkg::ACC_W'(ahr_pkg::HALF_Q16);
        return acc[21:16];
    endfunction

    logic [ahr_pkg::BACK_STAGES-1:0] vld_reg;
    logic                            adv;

    div_stage_t div_reg  [ahr_pkg::DIV_STEPS];
    div_stage_t div_next [ahr_pkg::DIV_STEPS];

    logic                              a_gray_reg, a_interp_reg;
    logic [ahr_pkg::HUE_W-1:0]         a_base_reg;
    logic signed [ahr_pkg::PROD_W-1:0] a_prod_reg, a_prod_next;

    logic                              b_gray_reg;
    logic [ahr_pkg::HUE_Q8_W-1:0]      b_hue_reg, b_hue_next;

    logic                              c_gray_reg;
    logic [ahr_pkg::HUE_Q8_W-1:0]      c_hue_reg, c_hue_next;

    logic                              d_gray_reg;
    logic [2:0]                        d_sector_reg, d_sector_next;
    logic [ahr_pkg::RP_W-1:0]          d_rp_reg, d_rp_next;

    logic                              e_gray_reg;
    logic [2:0]                        e_sector_reg;
    logic [ahr_pkg::PP_W-1:0]          e_p_reg, e_p_next;

    logic                              f_gray_reg;
    logic [2:0]                        f_sector_reg;
    logic [ahr_pkg::RQ_W-1:0]          f_prod_reg, f_prod_next;

    logic [ahr_pkg::PIX_W-1:0]         g_pix_reg, g_pix_next;

    assign adv       = !vld_reg[LAST] || pix_out.ready;
    assign job_ready = adv;

    // one quotient bit per stage, most significant first
    always_comb
    begin
        div_stage_t                 prev;
        logic [ahr_pkg::DIFF_W:0]   trial;
        logic                       ge;
        for (int k = 0; k < ahr_pkg::DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                prev.gray     = job.gray;
                prev.interp   = job.interp;
                prev.base_hue = job.base_hue;
                prev.span     = job.span;
                prev.den      = job.den;
                prev.rem      = job.num;
                prev.quo      = '0;
                trial         = {1'b0, prev.rem};
            end
            else
            begin
                prev  = div_reg[k-1];
                trial = {prev.rem, 1'b0};
            end
            ge              = trial >= {1'b0, prev.den};
            div_next[k]     = prev;
            div_next[k].rem = ge ? ahr_pkg::DIFF_W'(trial - {1'b0, prev.den})
                                 : ahr_pkg::DIFF_W'(trial);
            div_next[k].quo = {prev.quo[ahr_pkg::T_W-2:0], ge};
        end
    end

    assign a_prod_next = $signed({1'b0, div_reg[ahr_pkg::DIV_STEPS-1].quo})
                       * $signed(div_reg[ahr_pkg::DIV_STEPS-1].span);

    // delta truncated toward zero, then added to the base hue in q8
    always_comb
    begin
        logic signed [ahr_pkg::PROD_W-1:0] rnd;
        logic signed [ahr_pkg::HSUM_W-1:0] delta;
        logic signed [ahr_pkg::HSUM_W-1:0] base_q8;
        logic signed [ahr_pkg::HSUM_W-1:0] sum;
        rnd     = a_prod_reg + (a_prod_reg[ahr_pkg::PROD_W-1] ? ahr_pkg::PROD_W'(255)
                                                              : ahr_pkg::PROD_W'(0));
        delta   = a_interp_reg ? ahr_pkg::HSUM_W'(rnd >>> 8) : '0;
        base_q8 = ahr_pkg::HSUM_W'({a_base_reg, 8'h00});
        sum     = base_q8 + delta;
        b_hue_next = sum[ahr_pkg::HUE_Q8_W-1:0];
    end

    // hue stays below two full turns, so one subtract wraps it
    assign c_hue_next = (b_hue_reg >= ahr_pkg::HUE_Q8_W'(ahr_pkg::TURN_Q8))
                      ? b_hue_reg - ahr_pkg::HUE_Q8_W'(ahr_pkg::TURN_Q8)
                      : b_hue_reg;

    always_comb
    begin
        logic [2:0]                   sec;
        logic [ahr_pkg::HUE_Q8_W-1:0] sec_base;
        logic [ahr_pkg::RP_W-1:0]     rem;
        sec      = '0;
        sec_base = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (c_hue_reg >= ahr_pkg::HUE_Q8_W'(k * ahr_pkg::SECTOR_Q8))
            begin
                sec      = 3'(k);
                sec_base = ahr_pkg::HUE_Q8_W'(k * ahr_pkg::SECTOR_Q8);
            end
        end
        rem           = ahr_pkg::RP_W'(c_hue_reg - sec_base);
        d_sector_next = sec;
        d_rp_next     = sec[0] ? ahr_pkg::RP_W'(ahr_pkg::SECTOR_Q8) - rem : rem;
    end

    assign e_p_next = ahr_pkg::PP_W'(ahr_pkg::CHROMA_Q16) * ahr_pkg::PP_W'(d_rp_reg);

    // divide by 15360: drop ten bits, then divide by 15 through a reciprocal
    assign f_prod_next = ahr_pkg::RQ_W'(e_p_reg[ahr_pkg::PP_W-1:10])
                       * ahr_pkg::RQ_W'(ahr_pkg::RECIP_15);

    always_comb
    begin
        logic [ahr_pkg::CH_W-1:0] x;
        logic [ahr_pkg::CH_W-1:0] c;
        logic [ahr_pkg::CH_W-1:0] r;
        logic [ahr_pkg::CH_W-1:0] g;
        logic [ahr_pkg::CH_W-1:0] b;
        x = f_prod_reg[ahr_pkg::RECIP_SHIFT +: ahr_pkg::CH_W];
        c = ahr_pkg::CH_W'(ahr_pkg::CHROMA_Q16);
        case (f_sector_reg)
            3'd0:    begin r = c;  g = x;  b = '0; end
            3'd1:    begin r = x;  g = c;  b = '0; end
            3'd2:    begin r = '0; g = c;  b = x;  end
            3'd3:    begin r = '0; g = x;  b = c;  end
            3'd4:    begin r = x;  g = '0; b = c;  end
            default: begin r = c;  g = '0; b = x;  end
        endcase
        r = r + ahr_pkg::CH_W'(ahr_pkg::OFFSET_Q16);
        g = g + ahr_pkg::CH_W'(ahr_pkg::OFFSET_Q16);
        b = b + ahr_pkg::CH_W'(ahr_pkg::OFFSET_Q16);
        g_pix_next = f_gray_reg ? ahr_pkg::GRAY_PIXEL : {chan5(r), chan6(g), chan5(b)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ahr_pkg::BACK_STAGES-2:0], job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ahr_pkg::DIV_STEPS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            a_gray_reg   <= div_reg[ahr_pkg::DIV_STEPS-1].gray;
            a_interp_reg <= div_reg[ahr_pkg::DIV_STEPS-1].interp;
            a_base_reg   <= div_reg[ahr_pkg::DIV_STEPS-1].base_hue;
            a_prod_reg   <= a_prod_next;
            b_gray_reg   <= a_gray_reg;
            b_hue_reg    <= b_hue_next;
            c_gray_reg   <= b_gray_reg;
            c_hue_reg    <= c_hue_next;
            d_gray_reg   <= c_gray_reg;
            d_sector_reg <= d_sector_next;
            d_rp_reg     <= d_rp_next;
            e_gray_reg   <= d_gray_reg;
            e_sector_reg <= d_sector_reg;
            e_p_reg      <= e_p_next;
            f_gray_reg   <= e_gray_reg;
            f_sector_reg <= e_sector_reg;
            f_prod_reg   <= f_prod_next;
            g_pix_reg    <= g_pix_next;
        end
    end

    assign pix_out.valid       = vld_reg[LAST];
    assign pix_out.pixel_color = g_pix_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/altitude_hue_ramp_rgb565.sv -----
// Altitude hue ramp, rgb565 output.
// alt_in: valid/ready channel carrying alt_valid and a 17-bit signed altitude
//   in feet; each item gives exactly one pixel_color item on pix_out, in order.
// cfg: valid/ready write port, index 0..5 selects the low/mid/high stop
//   altitudes then the low/mid/high stop hues; other indexes are ignored.
//   cfg.ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle while the receiver takes every item, with
//   the 17-stage fraction divider and 7 color stages all advancing together.
// Reset: stops return to 2000/10000/40000 ft and 20/140/300 degrees, all
//   item stages and the queue empty.
// Stall: a held pix_out.ready freezes the back pipeline; the 4-entry queue
//   and the front job register keep taking items until they fill, then
//   alt_in.ready drops. One bubble follows the release of a full queue.
// Depends on ahr_pkg, ahr_ifs, ahr_front, ahr_queue and ahr_back.
`default_nettype none

module altitude_hue_ramp_rgb565 (
    input  logic       clk,
    input  logic       rst_n,
    ahr_cfg_if.sink    cfg,
    ahr_in_if.sink     alt_in,
    ahr_out_if.source  pix_out
);

    ahr_pkg::ahr_job_t front_job;
    logic              front_valid;
    logic              front_ready;
    ahr_pkg::ahr_job_t queue_job;
    logic              queue_valid;
    logic              queue_ready;

    ahr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .alt_in    (alt_in),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    ahr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (queue_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    ahr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (queue_job),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .pix_out   (pix_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ahr_checker.sv -----
// ahr_checker: port-level checks on the altitude hue ramp, tracking items
// in flight; bound to the top level.
// Depends on altitude_hue_ramp_rgb565 and ahr_pkg.
`default_nettype none

module ahr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ahr_pkg::PIX_W-1:0] pixel_color
);

    logic [5:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // no pixel without an item accepted before it
    a_no_orphan_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("pixel shown with no item in flight");

    // an empty block always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> in_ready)
        else $error("input stalled while block is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_color))
        else $error("stalled pixel changed or dropped");

endmodule

bind altitude_hue_ramp_rgb565 ahr_checker u_ahr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (alt_in.valid),
    .in_ready    (alt_in.ready),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_color (pix_out.pixel_color)
);

`default_nettype wire
